>>> design/json_top_level_bool_scanner_assert.svh
// Assertion macros used by the scanner's checker file.
// Needs clock and reset in the scope where the macros are used.
`ifndef JSON_TOP_LEVEL_BOOL_SCANNER_ASSERT_SVH
`define JSON_TOP_LEVEL_BOOL_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define JTBS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define JTBS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/jtbs_pkg.sv
// Package for the JSON top-level boolean scanner: sizes, character codes,
// register indexes, outcome codes, the classified transaction type and the literal table.
package jtbs_pkg;

   localparam int MAX_KEY_BYTES = 8;
   localparam int MAX_NESTING   = 255;

   localparam int KEY_W      = 8 * MAX_KEY_BYTES;
   localparam int KEY_LEN_W  = 4;
   localparam int KEY_POS_W  = $clog2(MAX_KEY_BYTES + 1);
   localparam int KEY_IDX_W  = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
   localparam int DEPTH_W    = $clog2(MAX_NESTING + 1);
   localparam int LIT_POS_W  = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CHAR_NUL       = 8'h00;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_COLON     = 8'h3A;
   localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
   localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
   localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
   localparam logic [7:0] CHAR_T         = 8'h74;
   localparam logic [7:0] CHAR_F         = 8'h66;

   localparam logic [LIT_POS_W-1:0] LEN_TRUE  = LIT_POS_W'(4);
   localparam logic [LIT_POS_W-1:0] LEN_FALSE = LIT_POS_W'(5);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_BYTES     = 2'd0,
      CSR_KEY_LENGTH    = 2'd1,
      CSR_DEFAULT_VALUE = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_TRUE      = 2'd0,
      OUT_FALSE     = 2'd1,
      OUT_ABSENT    = 2'd2,
      OUT_MALFORMED = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_body;
      logic       is_zero;
      logic       is_space;
      logic       is_colon;
      logic       is_quote;
      logic       is_backslash;
      logic       is_open;
      logic       is_close;
   } item_type;

   function automatic logic [7:0] lit_char(input logic is_false,
                                           input logic [LIT_POS_W-1:0] pos);
      logic [7:0] ch;
      ch = CHAR_NUL;
      if (is_false) begin
         case (pos)
            3'd0:    ch = 8'h66;
            3'd1:    ch = 8'h61;
            3'd2:    ch = 8'h6C;
            3'd3:    ch = 8'h73;
            3'd4:    ch = 8'h65;
            default: ch = CHAR_NUL;
         endcase
      end else begin
         case (pos)
            3'd0:    ch = 8'h74;
            3'd1:    ch = 8'h72;
            3'd2:    ch = 8'h75;
            3'd3:    ch = 8'h65;
            default: ch = CHAR_NUL;
         endcase
      end
      return ch;
   endfunction

endpackage

>>> design/jtbs_ifs.sv
// Channel interfaces of the scanner: body bytes in, results out, register writes.
// Depends on jtbs_pkg.
interface jtbs_req_if import jtbs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_body;
   modport source (output valid, data_byte, end_of_body, input ready);
   modport sink (input valid, data_byte, end_of_body, output ready);
endinterface

interface jtbs_rsp_if import jtbs_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       field_value;
   logic [1:0] outcome;
   modport source (output valid, field_value, outcome, input ready);
   modport sink (input valid, field_value, outcome, output ready);
endinterface

interface jtbs_csr_if import jtbs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

>>> design/jtbs_front.sv
// Front end: takes body bytes and registers them with their character class.
// Depends on jtbs_pkg and jtbs_ifs.
module jtbs_front import jtbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   jtbs_req_if.sink    req_chan,
   output logic        out_valid,
   output item_type    out_item,
   input  logic        out_ready
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   item_type item_in;
   logic     take;

   assign req_chan.ready = !valid_ff || out_ready;
   assign take           = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in              = item_ff;
      valid_in             = valid_ff && !out_ready;
      if (take) begin
         valid_in             = 1'b1;
         item_in.data_byte    = req_chan.data_byte;
         item_in.end_of_body  = req_chan.end_of_body;
         item_in.is_zero      = req_chan.data_byte == CHAR_NUL;
         item_in.is_space     = req_chan.data_byte == CHAR_SPACE ||
                                req_chan.data_byte == CHAR_TAB;
         item_in.is_colon     = req_chan.data_byte == CHAR_COLON;
         item_in.is_quote     = req_chan.data_byte == CHAR_QUOTE;
         item_in.is_backslash = req_chan.data_byte == CHAR_BACKSLASH;
         item_in.is_open      = req_chan.data_byte == CHAR_LBRACE ||
                                req_chan.data_byte == CHAR_LBRACKET;
         item_in.is_close     = req_chan.data_byte == CHAR_RBRACE ||
                                req_chan.data_byte == CHAR_RBRACKET;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> design/jtbs_fifo.sv
// Short queue between front and back end, holding classified transactions.
// Depends on jtbs_pkg.
module jtbs_fifo import jtbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     in_ready,
   output logic     out_valid,
   output item_type out_item,
   input  logic     out_ready
);

   item_type                mem [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff;
   logic [FIFO_PTR_W-1:0]   rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic                    push;
   logic                    pop;

   assign in_ready  = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (push) begin
         mem[wr_ptr_ff] <= in_item;
      end
   end

endmodule

>>> design/jtbs_back.sv
// Back end: key compare, nesting and string tracking, colon and literal checks,
// configuration registers and the result register. Depends on jtbs_pkg and jtbs_ifs.
module jtbs_back import jtbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   input  item_type    in_item,
   output logic        in_ready,
   jtbs_csr_if.sink    csr_chan,
   jtbs_rsp_if.source  rsp_chan
);

   typedef enum logic [2:0] {
      PH_SEARCH,
      PH_COLON,
      PH_VALUE,
      PH_LITERAL,
      PH_DONE
   } phase_type;

   logic [KEY_W-1:0]     key_ff;
   logic [KEY_LEN_W-1:0] key_len_ff;
   logic                 default_ff;

   phase_type            phase_ff,   phase_in;
   logic [DEPTH_W-1:0]   depth_ff,   depth_in;
   logic                 instr_ff,   instr_in;
   logic                 esc_ff,     esc_in;
   logic                 cmp_ff,     cmp_in;
   logic [KEY_POS_W-1:0] kpos_ff,    kpos_in;
   logic [LIT_POS_W-1:0] lpos_ff,    lpos_in;
   logic                 lfalse_ff,  lfalse_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 field_ff,     field_in;
   outcome_type          outcome_ff,   outcome_in;

   logic                 pop;
   logic                 emit;
   outcome_type          emit_code;
   logic [KEY_POS_W-1:0] klen;
   logic [7:0]           key_want;
   logic [7:0]           lit_want;
   logic [LIT_POS_W-1:0] lit_len;
   logic [LIT_POS_W-1:0] lpos_next;
   logic [7:0]           b;

   assign csr_chan.ready = 1'b1;
   assign in_ready       = !rsp_valid_ff || rsp_chan.ready;
   assign pop            = in_valid && in_ready;
   assign b              = in_item.data_byte;

   assign klen      = (key_len_ff > KEY_LEN_W'(MAX_KEY_BYTES)) ?
                      KEY_POS_W'(MAX_KEY_BYTES) : KEY_POS_W'(key_len_ff);
   assign key_want  = key_ff[{kpos_ff[KEY_IDX_W-1:0], 3'b000} +: 8];
   assign lit_want  = lit_char(lfalse_ff, lpos_ff);
   assign lit_len   = lfalse_ff ? LEN_FALSE : LEN_TRUE;
   assign lpos_next = lpos_ff + 1'b1;

   always_comb begin
      phase_in  = phase_ff;
      depth_in  = depth_ff;
      instr_in  = instr_ff;
      esc_in    = esc_ff;
      cmp_in    = cmp_ff;
      kpos_in   = kpos_ff;
      lpos_in   = lpos_ff;
      lfalse_in = lfalse_ff;
      emit      = 1'b0;
      emit_code = OUT_ABSENT;

      if (phase_ff == PH_DONE) begin
      end else if (in_item.is_zero) begin
         emit      = 1'b1;
         emit_code = (phase_ff == PH_SEARCH) ? OUT_ABSENT : OUT_MALFORMED;
      end else begin
         case (phase_ff)
            PH_COLON: begin
               if (in_item.is_colon) begin
                  phase_in = PH_VALUE;
               end else if (!in_item.is_space) begin
                  emit      = 1'b1;
                  emit_code = OUT_MALFORMED;
               end
            end
            PH_VALUE: begin
               if (b == CHAR_T || b == CHAR_F) begin
                  lfalse_in = b == CHAR_F;
                  lpos_in   = LIT_POS_W'(1);
                  phase_in  = PH_LITERAL;
               end else if (!in_item.is_space) begin
                  emit      = 1'b1;
                  emit_code = OUT_MALFORMED;
               end
            end
            PH_LITERAL: begin
               if (lpos_ff >= lit_len || b != lit_want) begin
                  emit      = 1'b1;
                  emit_code = OUT_MALFORMED;
               end else begin
                  lpos_in = lpos_next;
                  if (lpos_next == lit_len) begin
                     emit      = 1'b1;
                     emit_code = lfalse_ff ? OUT_FALSE : OUT_TRUE;
                  end
               end
            end
            PH_SEARCH: begin
               if (cmp_ff && kpos_ff >= klen && in_item.is_quote) begin
                  // full key followed by its closing quote
                  cmp_in   = 1'b0;
                  kpos_in  = '0;
                  instr_in = 1'b0;
                  esc_in   = 1'b0;
                  phase_in = PH_COLON;
               end else begin
                  if (cmp_ff) begin
                     if (kpos_ff < klen && b == key_want) begin
                        kpos_in = kpos_ff + 1'b1;
                     end else begin
                        cmp_in = 1'b0;
                     end
                  end
                  if (instr_ff) begin
                     if (esc_ff) begin
                        esc_in = 1'b0;
                     end else if (in_item.is_backslash) begin
                        esc_in = 1'b1;
                     end else if (in_item.is_quote) begin
                        instr_in = 1'b0;
                     end
                  end else if (in_item.is_open) begin
                     if (depth_ff != DEPTH_W'(MAX_NESTING)) begin
                        depth_in = depth_ff + 1'b1;
                     end
                  end else if (in_item.is_close) begin
                     if (depth_ff != '0) begin
                        depth_in = depth_ff - 1'b1;
                     end
                  end else if (in_item.is_quote) begin
                     if (depth_ff == DEPTH_W'(1) && !cmp_in) begin
                        cmp_in  = 1'b1;
                        kpos_in = '0;
                     end
                     instr_in = 1'b1;
                     esc_in   = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      if (emit) begin
         phase_in = PH_DONE;
      end

      if (in_item.end_of_body) begin
         if (!emit && phase_in != PH_DONE) begin
            emit      = 1'b1;
            emit_code = (phase_in == PH_SEARCH) ? OUT_ABSENT : OUT_MALFORMED;
         end
         phase_in  = PH_SEARCH;
         depth_in  = '0;
         instr_in  = 1'b0;
         esc_in    = 1'b0;
         cmp_in    = 1'b0;
         kpos_in   = '0;
         lpos_in   = '0;
         lfalse_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      field_in     = field_ff;
      outcome_in   = outcome_ff;
      if (pop && emit) begin
         rsp_valid_in = 1'b1;
         outcome_in   = emit_code;
         case (emit_code)
            OUT_TRUE:  field_in = 1'b1;
            OUT_FALSE: field_in = 1'b0;
            default:   field_in = default_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         key_len_ff   <= KEY_LEN_W'(1);
         default_ff   <= 1'b0;
         phase_ff     <= PH_SEARCH;
         depth_ff     <= '0;
         instr_ff     <= 1'b0;
         esc_ff       <= 1'b0;
         cmp_ff       <= 1'b0;
         kpos_ff      <= '0;
         lpos_ff      <= '0;
         lfalse_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_index_type'(csr_chan.index))
               CSR_KEY_BYTES:     key_ff     <= csr_chan.wdata[KEY_W-1:0];
               CSR_KEY_LENGTH:    key_len_ff <= csr_chan.wdata[KEY_LEN_W-1:0];
               CSR_DEFAULT_VALUE: default_ff <= csr_chan.wdata[0];
               default: begin
               end
            endcase
         end
         if (pop) begin
            phase_ff  <= phase_in;
            depth_ff  <= depth_in;
            instr_ff  <= instr_in;
            esc_ff    <= esc_in;
            cmp_ff    <= cmp_in;
            kpos_ff   <= kpos_in;
            lpos_ff   <= lpos_in;
            lfalse_ff <= lfalse_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
      field_ff   <= field_in;
      outcome_ff <= outcome_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.field_value = field_ff;
   assign rsp_chan.outcome     = outcome_ff;

endmodule

>>> design/json_top_level_bool_scanner.sv
// Top level of the JSON top-level boolean scanner.
// Depends on jtbs_pkg, jtbs_ifs, jtbs_front, jtbs_fifo and jtbs_back.
//
// Usage:
//   req_chan carries one body byte per transaction with end_of_body on the
//   last byte; a zero byte ends the text early. rsp_chan carries at most one
//   result per body: field_value and outcome. csr_chan writes key_bytes (0),
//   key_length (1) and default_value (2); it is always ready; the user must
//   ensure it is written only while the scanner is idle (not enforced).
//   Throughput: one byte per cycle, sustained, as long as rsp_chan is not
//   stalled. Every byte passes the classifying front register, the 4-entry
//   queue and the scan state update, each once per cycle.
//   Path: the deciding byte is held in the front register, then in the queue,
//   and its result is then held in the result register that drives rsp_chan.
//   Stall: while rsp_chan is held off the result register holds; the back
//   end stops, the queue and the front register fill and req_chan.ready drops.
//   Reset (synchronous, active high): clears all scan state, the queue and
//   the result register; key_bytes 0, key_length 1, default_value 0.
module json_top_level_bool_scanner import jtbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   jtbs_req_if.sink    req_chan,
   jtbs_csr_if.sink    csr_chan,
   jtbs_rsp_if.source  rsp_chan
);

   logic     front_valid;
   item_type front_item;
   logic     front_ready;
   logic     queue_valid;
   item_type queue_item;
   logic     queue_ready;

   jtbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .out_valid (front_valid),
      .out_item  (front_item),
      .out_ready (front_ready)
   );

   jtbs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_item   (front_item),
      .in_ready  (front_ready),
      .out_valid (queue_valid),
      .out_item  (queue_item),
      .out_ready (queue_ready)
   );

   jtbs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (queue_valid),
      .in_item  (queue_item),
      .in_ready (queue_ready),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> design/jtbs_checker.sv
// Port-level checker for the scanner, bound to the top level.
// Depends on jtbs_pkg and json_top_level_bool_scanner_assert.svh.
`include "json_top_level_bool_scanner_assert.svh"

module jtbs_checker import jtbs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_field_value,
   input logic [1:0] rsp_outcome,
   input logic       csr_ready
);

   `JTBS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_outcome) && $stable(rsp_field_value), "result changed while stalled")
   `JTBS_ASSERT_NOW(a_true_value, rsp_valid && rsp_outcome == OUT_TRUE, rsp_field_value, "true outcome without value 1")
   `JTBS_ASSERT_NOW(a_false_value, rsp_valid && rsp_outcome == OUT_FALSE, !rsp_field_value, "false outcome without value 0")
   `JTBS_ASSERT_NOW(a_reset_clear, $past(reset), !rsp_valid && csr_ready, "result pending right after reset")

endmodule

bind json_top_level_bool_scanner jtbs_checker u_jtbs_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_field_value (rsp_chan.field_value),
   .rsp_outcome     (rsp_chan.outcome),
   .csr_ready       (csr_chan.ready)
);

>>> verif/json_top_level_bool_scanner_tb.sv
// Testbench for json_top_level_bool_scanner: directed bodies, then random JSON-like bodies under
// several key settings; each result is checked against an in-bench scan predictor or a typed table row.
// Depends on jtbs_pkg, jtbs_ifs and the scanner RTL.
`timescale 1ns / 1ps

module json_top_level_bool_scanner_tb import jtbs_pkg::*; ();

   typedef enum logic [2:0] {
      SEEK_KEY, SEEK_COLON, SEEK_VALUE, IN_LITERAL, BODY_DONE
   } scan_phase_type;

   typedef struct packed {
      logic        field_value;
      outcome_type outcome;
   } verdict_type;

   typedef struct packed {
      logic          is_csr;
      csr_index_type idx;
      logic [63:0]   wdata;
      logic [7:0]    data;
      logic          eob;
      logic          typed;
      logic          val;
      outcome_type   out;
   } dir_row_type;

   localparam int N_DIR = 26;
   localparam dir_row_type DIR_TAB [N_DIR] = '{
      '{1'b0, CSR_KEY_BYTES, 64'h0, "x", 1'b1, 1'b1, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_NUL, 1'b0, 1'b1, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, 8'hFF, 1'b1, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b1, CSR_KEY_BYTES, 64'h6B6F, 8'h0, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b1, CSR_KEY_LENGTH, 64'h2, 8'h0, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b1, CSR_DEFAULT_VALUE, 64'h1, 8'h0, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      // depth underflow, then a proper top-level true
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_RBRACE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_LBRACE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_QUOTE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "o", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "k", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_QUOTE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_COLON, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_T, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "r", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "u", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "e", 1'b0, 1'b1, 1'b1, OUT_TRUE},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_RBRACE, 1'b1, 1'b0, 1'b0, OUT_ABSENT},
      // body ends inside the literal
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_LBRACE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_QUOTE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "o", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, "k", 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_QUOTE, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_TAB, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_COLON, 1'b0, 1'b0, 1'b0, OUT_ABSENT},
      '{1'b0, CSR_KEY_BYTES, 64'h0, CHAR_F, 1'b1, 1'b1, 1'b1, OUT_MALFORMED}
   };

   localparam int ITEM_TARGET  = 1650;
   localparam int SETTLE_WAIT  = 12;
   localparam int SQUEEZE_LEN  = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   jtbs_req_if req_if ();
   jtbs_rsp_if rsp_if ();
   jtbs_csr_if csr_if ();

   json_top_level_bool_scanner u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .csr_chan (csr_if),
      .rsp_chan (rsp_if)
   );

   always #2 clock = ~clock;

   // predictor copy of the registers and scan state
   logic [63:0]    key_reg;
   logic [3:0]     key_len_reg;
   logic           dflt_reg;
   int unsigned    depth;
   bit             in_str;
   bit             esc_pend;
   bit             cmp_on;
   int unsigned    cmp_pos;
   scan_phase_type phase_st;
   int unsigned    lit_pos;
   bit             lit_false;

   verdict_type  pending_verdicts[$];
   int           mismatches = 0;
   int           items_sent = 0;
   int           squeeze_asked = 0;
   bit           calm_send = 1'b0;

   // typed expectation travelling with the byte on the input channel
   logic         row_typed = 1'b0;
   verdict_type  row_verdict = '0;

   logic [7:0]   body_bytes[$];
   logic [63:0]  phase_key;
   int           phase_len;

   task automatic report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 50)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic void clear_scan();
      depth = 0;
      in_str = 1'b0;
      esc_pend = 1'b0;
      cmp_on = 1'b0;
      cmp_pos = 0;
      phase_st = SEEK_KEY;
      lit_pos = 0;
      lit_false = 1'b0;
   endfunction

   function automatic verdict_type conclude(outcome_type o);
      verdict_type v;
      v.outcome = o;
      if (o == OUT_TRUE)
         v.field_value = 1'b1;
      else if (o == OUT_FALSE)
         v.field_value = 1'b0;
      else
         v.field_value = dflt_reg;
      phase_st = BODY_DONE;
      return v;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic eob,
                                     output bit hit, output verdict_type v);
      int unsigned klen;
      bit key_closed;
      string txt;
      hit = 1'b0;
      v = '0;
      key_closed = 1'b0;
      klen = (key_len_reg > MAX_KEY_BYTES) ? MAX_KEY_BYTES : key_len_reg;
      if (phase_st != BODY_DONE) begin
         if (b == CHAR_NUL) begin
            hit = 1'b1;
            v = conclude(phase_st == SEEK_KEY ? OUT_ABSENT : OUT_MALFORMED);
         end else begin
            case (phase_st)
               SEEK_COLON: begin
                  if (b == CHAR_SPACE || b == CHAR_TAB) ;
                  else if (b == CHAR_COLON) phase_st = SEEK_VALUE;
                  else begin
                     hit = 1'b1;
                     v = conclude(OUT_MALFORMED);
                  end
               end
               SEEK_VALUE: begin
                  if (b == CHAR_SPACE || b == CHAR_TAB) ;
                  else if (b == CHAR_T || b == CHAR_F) begin
                     lit_false = (b == CHAR_F);
                     lit_pos = 1;
                     phase_st = IN_LITERAL;
                  end else begin
                     hit = 1'b1;
                     v = conclude(OUT_MALFORMED);
                  end
               end
               IN_LITERAL: begin
                  txt = lit_false ? "false" : "true";
                  if (lit_pos >= txt.len() || b != txt[lit_pos]) begin
                     hit = 1'b1;
                     v = conclude(OUT_MALFORMED);
                  end else begin
                     lit_pos++;
                     if (lit_pos == txt.len()) begin
                        hit = 1'b1;
                        v = conclude(lit_false ? OUT_FALSE : OUT_TRUE);
                     end
                  end
               end
               SEEK_KEY: begin
                  if (cmp_on) begin
                     if (cmp_pos < klen) begin
                        if (b == key_reg[8*cmp_pos +: 8]) cmp_pos++;
                        else cmp_on = 1'b0;
                     end else if (b == CHAR_QUOTE) begin
                        cmp_on = 1'b0;
                        cmp_pos = 0;
                        in_str = 1'b0;
                        esc_pend = 1'b0;
                        phase_st = SEEK_COLON;
                        key_closed = 1'b1;
                     end else begin
                        cmp_on = 1'b0;
                     end
                  end
                  if (!key_closed) begin
                     if (in_str) begin
                        if (esc_pend) esc_pend = 1'b0;
                        else if (b == CHAR_BACKSLASH) esc_pend = 1'b1;
                        else if (b == CHAR_QUOTE) in_str = 1'b0;
                     end else if (b == CHAR_LBRACE || b == CHAR_LBRACKET) begin
                        if (depth < MAX_NESTING) depth++;
                     end else if (b == CHAR_RBRACE || b == CHAR_RBRACKET) begin
                        if (depth > 0) depth--;
                     end else if (b == CHAR_QUOTE) begin
                        if (depth == 1 && !cmp_on) begin
                           cmp_on = 1'b1;
                           cmp_pos = 0;
                        end
                        in_str = 1'b1;
                        esc_pend = 1'b0;
                     end
                  end
               end
               default: ;
            endcase
         end
      end
      if (eob) begin
         if (!hit && phase_st != BODY_DONE) begin
            hit = 1'b1;
            v = conclude(phase_st == SEEK_KEY ? OUT_ABSENT : OUT_MALFORMED);
         end
         clear_scan();
      end
   endfunction

   // transaction monitor: predicts on accepted bytes, checks accepted results
   always @(posedge clock) begin
      bit          hit;
      verdict_type v;
      verdict_type want;
      if (reset) begin
         key_reg <= '0;
         key_len_reg <= 4'd1;
         dflt_reg <= 1'b0;
         clear_scan();
         pending_verdicts.delete();
      end else begin
         if (csr_if.valid && csr_if.ready) begin
            case (csr_index_type'(csr_if.index))
               CSR_KEY_BYTES:     key_reg <= csr_if.wdata;
               CSR_KEY_LENGTH:    key_len_reg <= csr_if.wdata[3:0];
               CSR_DEFAULT_VALUE: dflt_reg <= csr_if.wdata[0];
               default: ;
            endcase
         end
         if (req_if.valid && req_if.ready) begin
            scan_byte(req_if.data_byte, req_if.end_of_body, hit, v);
            if (row_typed) begin
               hit = 1'b1;
               v = row_verdict;
            end
            if (hit) pending_verdicts.push_back(v);
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result: value %0b outcome %0d",
                                         rsp_if.field_value, rsp_if.outcome));
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_if.field_value !== want.field_value)
                  report_mismatch($sformatf("field_value %0b, expected %0b",
                                            rsp_if.field_value, want.field_value));
               if (rsp_if.outcome !== want.outcome)
                  report_mismatch($sformatf("outcome %0d, expected %0d",
                                            rsp_if.outcome, want.outcome));
            end
         end
      end
   end

   function automatic int pick_gap(bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] rand_char();
      case ($urandom_range(0, 13))
         0:       return CHAR_QUOTE;
         1:       return CHAR_BACKSLASH;
         2:       return CHAR_LBRACE;
         3:       return CHAR_RBRACE;
         4:       return CHAR_LBRACKET;
         5:       return CHAR_RBRACKET;
         6:       return CHAR_COLON;
         7:       return CHAR_SPACE;
         8:       return CHAR_TAB;
         9:       return CHAR_T;
         10:      return CHAR_F;
         11:      return CHAR_NUL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [63:0] make_key(bit plain);
      logic [63:0] k;
      for (int i = 0; i < 8; i++)
         k[8*i +: 8] = (plain || $urandom_range(0, 99) < 70) ?
                       8'($urandom_range(97, 122)) : rand_char();
      return k;
   endfunction

   task automatic send_item(logic [7:0] d, logic eob, logic typed, verdict_type v);
      int gap;
      gap = pick_gap(calm_send);
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data_byte <= d;
      req_if.end_of_body <= eob;
      row_typed <= typed;
      row_verdict <= v;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   task automatic csr_write(csr_index_type idx, logic [63:0] d);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= d;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // drain: no byte offered, every expected result in, then the pipeline latency
   task automatic settle();
      @(negedge clock);
      req_if.valid <= 1'b0;
      row_typed <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic push_text(string s);
      foreach (s[i]) body_bytes.push_back(s[i]);
   endtask

   task automatic push_ws();
      repeat ($urandom_range(0, 2))
         body_bytes.push_back($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
   endtask

   task automatic push_word();
      body_bytes.push_back(CHAR_QUOTE);
      repeat ($urandom_range(1, 4)) body_bytes.push_back(8'($urandom_range(97, 122)));
      body_bytes.push_back(CHAR_QUOTE);
   endtask

   task automatic push_key();
      body_bytes.push_back(CHAR_QUOTE);
      for (int i = 0; i < phase_len && i < MAX_KEY_BYTES; i++)
         body_bytes.push_back(phase_key[8*i +: 8]);
      body_bytes.push_back(CHAR_QUOTE);
   endtask

   task automatic push_member(bit with_key);
      if (with_key) push_key();
      else push_word();
      push_ws();
      body_bytes.push_back(CHAR_COLON);
      push_ws();
      if (with_key) begin
         push_text($urandom_range(0, 1) ? "false" : "true");
      end else begin
         case ($urandom_range(0, 6))
            0, 1: repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom_range(48, 57)));
            2: begin
               push_text("\"a");
               body_bytes.push_back(CHAR_BACKSLASH);
               push_text("\"b\"");
            end
            3: begin
               body_bytes.push_back(CHAR_LBRACE);
               push_key();
               push_text(":true");
               body_bytes.push_back(CHAR_RBRACE);
            end
            4: begin
               body_bytes.push_back(CHAR_LBRACKET);
               push_key();
               body_bytes.push_back(CHAR_RBRACKET);
            end
            5: push_key();
            default: push_text("null");
         endcase
      end
   endtask

   task automatic build_body();
      int r;
      int cut;
      body_bytes.delete();
      r = $urandom_range(0, 99);
      if (r < 10)
         repeat ($urandom_range(1, 3))
            body_bytes.push_back($urandom_range(0, 1) ? CHAR_RBRACE : CHAR_RBRACKET);
      if (r < 85) begin
         body_bytes.push_back(CHAR_LBRACE);
         repeat ($urandom_range(0, 2)) begin
            push_member(1'b0);
            push_text(",");
            push_ws();
         end
         push_member(1'b1);
         if ($urandom_range(0, 1)) begin
            push_text(",");
            push_member(1'b0);
         end
         body_bytes.push_back(CHAR_RBRACE);
         if (r >= 60) begin
            cut = $urandom_range(0, body_bytes.size() - 1);
            case ($urandom_range(0, 2))
               0: body_bytes[cut] = rand_char();
               1: body_bytes[cut] = CHAR_NUL;
               default: while (body_bytes.size() > cut + 1) void'(body_bytes.pop_back());
            endcase
         end
      end else begin
         repeat ($urandom_range(1, 16)) body_bytes.push_back(rand_char());
      end
   endtask

   task automatic send_body();
      for (int i = 0; i < body_bytes.size(); i++)
         send_item(body_bytes[i], i == body_bytes.size() - 1, 1'b0, '0);
   endtask

   // result side: random stalls, calm stretches, and long hold-offs on request
   initial begin : rsp_ready_drive
      int  stall_left;
      int  squeezes_done;
      int  calm_left;
      bit  calm;
      stall_left = 0;
      squeezes_done = 0;
      calm_left = 0;
      calm = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_asked > squeezes_done) begin
            squeezes_done++;
            stall_left = SQUEEZE_LEN;
         end
         if (calm_left == 0) begin
            calm = ($urandom_range(0, 3) == 0);
            calm_left = $urandom_range(20, 120);
         end
         calm_left--;
         if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else if (calm || $urandom_range(0, 99) < 75) begin
            rsp_if.ready <= 1'b1;
         end else begin
            rsp_if.ready <= 1'b0;
            stall_left = pick_gap(1'b0);
         end
      end
   end

   initial begin : stimulus
      bit          last_csr;
      int          phase;
      int          target;
      int          nbodies;
      logic [63:0] wd;
      logic        dflt;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.end_of_body = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.wdata = '0;
      phase_key = '0;
      phase_len = 1;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      last_csr = 1'b0;
      for (int i = 0; i < N_DIR; i++) begin
         if (DIR_TAB[i].is_csr) begin
            if (!last_csr) settle();
            csr_write(DIR_TAB[i].idx, DIR_TAB[i].wdata);
         end else begin
            send_item(DIR_TAB[i].data, DIR_TAB[i].eob, DIR_TAB[i].typed,
                      '{DIR_TAB[i].val, DIR_TAB[i].out});
         end
         last_csr = DIR_TAB[i].is_csr;
      end

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         settle();
         case (phase % 5)
            0: begin phase_len = 8; phase_key = make_key(1'b1); dflt = 1'b0; end
            1: begin phase_len = 1; phase_key = make_key(1'b1); dflt = 1'b1; end
            2: begin
               phase_len = 0;
               phase_key = (phase % 10 == 2) ? '1 : {$urandom, $urandom};
               dflt = 1'($urandom_range(0, 1));
            end
            3: begin phase_len = 15; phase_key = make_key(1'b1); dflt = 1'($urandom_range(0, 1)); end
            default: begin
               phase_len = $urandom_range(0, 15);
               phase_key = make_key(1'b0);
               dflt = 1'($urandom_range(0, 1));
            end
         endcase
         csr_write(CSR_KEY_BYTES, phase_key);
         wd = {$urandom, $urandom};
         wd[3:0] = 4'(phase_len);
         csr_write(CSR_KEY_LENGTH, wd);
         wd = {$urandom, $urandom};
         wd[0] = dflt;
         csr_write(CSR_DEFAULT_VALUE, wd);

         // nesting saturates at the top, so the closes bring it back to depth one
         if (phase == 0) begin
            body_bytes.delete();
            repeat (MAX_NESTING + 5) body_bytes.push_back(CHAR_LBRACKET);
            repeat (MAX_NESTING - 1) body_bytes.push_back(CHAR_RBRACKET);
            push_key();
            push_text(":true");
            calm_send = 1'b1;
            send_body();
         end

         target = items_sent + 150;
         nbodies = 0;
         while (items_sent < target) begin
            calm_send = ($urandom_range(0, 3) == 0);
            if (nbodies == 3 && (phase == 1 || phase == 5)) squeeze_asked++;
            build_body();
            send_body();
            nbodies++;
         end
         phase++;
      end

      settle();
      if (mismatches == 0)
         $display("json_top_level_bool_scanner test passed");
      else
         $display("json_top_level_bool_scanner test failed");
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("json_top_level_bool_scanner test failed");
      $finish;
   end

endmodule

>>> json_top_level_bool_scanner.f
+incdir+design
design/jtbs_pkg.sv
design/jtbs_ifs.sv
design/jtbs_front.sv
design/jtbs_fifo.sv
design/jtbs_back.sv
design/json_top_level_bool_scanner.sv
design/jtbs_checker.sv
verif/json_top_level_bool_scanner_tb.sv
